// ----- design/gbn_pkg.sv -----
// Shared types, codes and constants of the Go-Back-N sender window block.
package gbn_pkg;

	localparam int MAX_WINDOW = 32;
	localparam int SEQ_W = 32;
	localparam int WIN_W = 6;
	localparam int CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int FIFO_DEPTH = 2;

	// event codes
	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_ACK = 2'd1;
	localparam logic [1:0] REQ_TIMEOUT = 2'd2;
	localparam logic [1:0] REQ_NONE = 2'd3;

	// run status codes
	localparam logic [1:0] ST_RUNNING = 2'd0;
	localparam logic [1:0] ST_ABORTED = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	localparam logic [1:0] DUP_LIMIT = 2'd3;
	localparam logic [1:0] TIMEOUT_LIMIT = 2'd3;

	// configuration register indexes
	localparam logic CFG_WINDOW_SIZE = 1'b0;
	localparam logic CFG_TOTAL_SEGMENTS = 1'b1;

	typedef struct packed {
		logic [WIN_W-1:0] window_size;
		logic [SEQ_W-1:0] total_segments;
	} cfg_t;

	// one run of results handed from front to back
	typedef struct packed {
		logic stat_only;
		logic [SEQ_W-1:0] start;
		logic [CNT_W-1:0] cnt;
		logic resend;
		logic [1:0] status;
	} cmd_t;

	function automatic logic [CNT_W-1:0] eff_window(input logic [WIN_W-1:0] w);
		logic [CNT_W-1:0] r;
		if (w == '0) begin
			r = CNT_W'(1);
		end else if (32'(w) > 32'(MAX_WINDOW)) begin
			r = CNT_W'(MAX_WINDOW);
		end else begin
			r = CNT_W'(w);
		end
		return r;
	endfunction

endpackage

// ----- design/gbn_if.sv -----
// Channel interfaces: event input and segment result output.
interface gbn_evt_if import gbn_pkg::*; ();
	logic valid;
	logic ready;
	logic [1:0] req_type;
	logic [SEQ_W-1:0] ack_seq;

	modport source (output valid, output req_type, output ack_seq, input ready);
	modport sink (input valid, input req_type, input ack_seq, output ready);
endinterface

interface gbn_res_if import gbn_pkg::*; ();
	logic valid;
	logic ready;
	logic seg_valid;
	logic [SEQ_W-1:0] seg_number;
	logic is_resend;
	logic last_of_run;
	logic [1:0] status;

	modport source (output valid, output seg_valid, output seg_number, output is_resend,
		output last_of_run, output status, input ready);
	modport sink (input valid, input seg_valid, input seg_number, input is_resend,
		input last_of_run, input status, output ready);
endinterface

// ----- design/go_back_n_sender_window_unit.sv -----
// Top level of the Go-Back-N sender window unit.
//
// Usage:
//  - evt channel (valid/ready): one transaction per event, req_type 0 start,
//    1 cumulative ACK (ack_seq), 2 receive timeout; code 3 only yields a status result.
//  - res channel (valid/ready): results per event, in order. Each names a
//    segment to send (seg_valid 1) or, when nothing is sent, is a single
//    status result. last_of_run marks the final result of an event.
//  - cfg port: cfg_we with cfg_index 0 window_size, 1 total_segments.
//    Write only while the unit is idle.
//  - Flow: the front handles each event in turn through capture, state update,
//    window end and plan, set by its state sequencer, and takes no new event
//    until plan has pushed its command. The back then emits results one per
//    cycle while res is ready.
//  - A 2-entry command queue sits between front and back; when res stalls,
//    the back holds its output register, the queue fills and the front
//    stops taking events. No results are lost or duplicated.
//  - Reset (arst_n low) clears window state to zero, status to running,
//    window_size to 4 and total_segments to 0.
module go_back_n_sender_window_unit import gbn_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_index,
	input logic [SEQ_W-1:0] cfg_wdata,
	gbn_evt_if.sink evt,
	gbn_res_if.source res
);

	cfg_t cfg_q;
	cmd_t f_cmd;
	cmd_t q_cmd;
	logic f_push;
	logic q_full;
	logic q_valid;
	logic q_pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_size <= WIN_W'(4);
			cfg_q.total_segments <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WINDOW_SIZE: cfg_q.window_size <= cfg_wdata[WIN_W-1:0];
				CFG_TOTAL_SEGMENTS: cfg_q.total_segments <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// event classification and window bookkeeping
	gbn_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.evt(evt),
		.cfg(cfg_q),
		.cmd(f_cmd),
		.cmd_push(f_push),
		.cmd_full(q_full)
	);

	gbn_cmd_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(f_push),
		.din(f_cmd),
		.full(q_full),
		.pop(q_pop),
		.dout(q_cmd),
		.valid(q_valid)
	);

	// run expansion onto the result channel
	gbn_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(q_cmd),
		.cmd_valid(q_valid),
		.cmd_pop(q_pop),
		.res(res)
	);

endmodule

// ----- design/gbn_front.sv -----
// Front end: accepts events, updates window state, plans one run per event.
module gbn_front import gbn_pkg::*; (
	input logic clk,
	input logic arst_n,
	gbn_evt_if.sink evt,
	input cfg_t cfg,
	output cmd_t cmd,
	output logic cmd_push,
	input logic cmd_full
);

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_UPD = 2'd1;
	localparam logic [1:0] F_END = 2'd2;
	localparam logic [1:0] F_PLAN = 2'd3;

	logic [1:0] fs_q;
	logic [1:0] req_q;
	logic [SEQ_W-1:0] ack_q;
	logic [SEQ_W-1:0] base_q;
	logic [SEQ_W-1:0] nts_q;
	logic [SEQ_W-1:0] last_ack_q;
	logic [1:0] dup_q;
	logic [1:0] to_q;
	logic [1:0] run_q;
	logic rewind_q;
	logic early_q;
	logic done_q;
	logic [SEQ_W-1:0] start_q;
	logic [SEQ_W:0] end_q;

	logic [1:0] dup_nx;
	logic [1:0] to_nx;
	logic [SEQ_W:0] lim;
	logic [SEQ_W:0] diff;
	logic has_seg;
	logic upd_rewind;
	logic upd_early;

	assign evt.ready = (fs_q == F_IDLE);
	assign dup_nx = (dup_q < DUP_LIMIT) ? dup_q + 2'd1 : dup_q;
	assign to_nx = (to_q < TIMEOUT_LIMIT) ? to_q + 2'd1 : to_q;
	assign lim = {1'b0, base_q} + (SEQ_W + 1)'(eff_window(cfg.window_size));
	assign diff = end_q - {1'b0, start_q};
	assign has_seg = ({1'b0, start_q} < end_q);

	// rewind and early-out flags for the event held in req_q/ack_q
	always_comb begin
		upd_rewind = 1'b0;
		upd_early = 1'b0;
		priority if (run_q != ST_RUNNING || req_q == REQ_NONE) begin
			upd_early = 1'b1;
		end else if (req_q == REQ_ACK) begin
			upd_rewind = (ack_q == last_ack_q) && (dup_nx == DUP_LIMIT);
		end else if (req_q == REQ_TIMEOUT) begin
			upd_rewind = 1'b1;
			upd_early = (to_nx == TIMEOUT_LIMIT);
		end else begin
		end
	end

	always_comb begin
		cmd = '0;
		cmd.status = run_q;
		if (early_q) begin
			cmd.stat_only = 1'b1;
		end else if (done_q) begin
			cmd.stat_only = 1'b1;
			cmd.status = ST_DONE;
		end else if (has_seg) begin
			cmd.start = start_q;
			cmd.cnt = diff[CNT_W-1:0];
			cmd.resend = rewind_q;
		end else begin
			cmd.stat_only = 1'b1;
		end
	end

	assign cmd_push = (fs_q == F_PLAN) && !cmd_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q <= F_IDLE;
			base_q <= '0;
			nts_q <= '0;
			last_ack_q <= '0;
			dup_q <= '0;
			to_q <= '0;
			run_q <= ST_RUNNING;
			rewind_q <= 1'b0;
			early_q <= 1'b0;
		end else begin
			unique case (fs_q)
				F_IDLE: begin
					if (evt.valid) begin
						fs_q <= F_UPD;
					end
				end
				F_UPD: begin
					rewind_q <= upd_rewind;
					early_q <= upd_early;
					fs_q <= F_END;
					if (run_q == ST_RUNNING && req_q != REQ_NONE) begin
						unique case (req_q)
							REQ_ACK: begin
								if (ack_q == last_ack_q) begin
									dup_q <= dup_nx;
								end else if (ack_q > last_ack_q) begin
									last_ack_q <= ack_q;
									base_q <= ack_q;
									dup_q <= '0;
									if (nts_q < ack_q) begin
										nts_q <= ack_q;
									end
								end
							end
							REQ_TIMEOUT: begin
								to_q <= to_nx;
								if (to_nx == TIMEOUT_LIMIT) begin
									run_q <= ST_ABORTED;
								end
							end
							default: begin
							end
						endcase
					end
				end
				F_END: begin
					fs_q <= F_PLAN;
				end
				F_PLAN: begin
					if (!cmd_full) begin
						fs_q <= F_IDLE;
						if (!early_q) begin
							if (done_q) begin
								run_q <= ST_DONE;
							end else if (has_seg) begin
								nts_q <= end_q[SEQ_W-1:0];
							end else begin
								nts_q <= start_q;
							end
						end
					end
				end
				default: fs_q <= F_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (fs_q == F_IDLE && evt.valid) begin
			req_q <= evt.req_type;
			ack_q <= evt.ack_seq;
		end
		if (fs_q == F_END) begin
			start_q <= rewind_q ? base_q : nts_q;
			end_q <= (lim > {1'b0, cfg.total_segments}) ? {1'b0, cfg.total_segments} : lim;
			done_q <= (base_q >= cfg.total_segments);
		end
	end

endmodule

// ----- design/gbn_cmd_fifo.sv -----
// Short command queue between front and back.
module gbn_cmd_fifo import gbn_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input cmd_t din,
	output logic full,
	input logic pop,
	output cmd_t dout,
	output logic valid
);

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int OCC_W = $clog2(FIFO_DEPTH + 1);

	cmd_t mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [OCC_W-1:0] occ_q;

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (32'(p) == FIFO_DEPTH - 1) ? '0 : p + PTR_W'(1);
	endfunction

	assign full = (32'(occ_q) == FIFO_DEPTH);
	assign valid = (occ_q != '0);
	assign dout = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			occ_q <= '0;
		end else begin
			if (push) begin
				wp_q <= bump(wp_q);
			end
			if (pop) begin
				rp_q <= bump(rp_q);
			end
			if (push && !pop) begin
				occ_q <= occ_q + OCC_W'(1);
			end else if (pop && !push) begin
				occ_q <= occ_q - OCC_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= din;
		end
	end

endmodule

// ----- design/gbn_back.sv -----
// Back end: expands each run into result transactions, one per cycle while res is ready.
module gbn_back import gbn_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cmd_t cmd,
	input logic cmd_valid,
	output logic cmd_pop,
	gbn_res_if.source res
);

	logic act_q;
	logic so_q;
	logic [SEQ_W-1:0] cur_q;
	logic [CNT_W-1:0] rem_q;
	logic rs_q;
	logic [1:0] st_q;

	logic ov_q;
	logic o_segv_q;
	logic [SEQ_W-1:0] o_seg_q;
	logic o_rs_q;
	logic o_last_q;
	logic [1:0] o_st_q;

	logic slot_free;
	logic emit;
	logic emit_last;

	assign slot_free = !ov_q || res.ready;
	assign emit = act_q && slot_free;
	assign emit_last = so_q || (rem_q == CNT_W'(1));
	assign cmd_pop = cmd_valid && (!act_q || (emit && emit_last));

	assign res.valid = ov_q;
	assign res.seg_valid = o_segv_q;
	assign res.seg_number = o_seg_q;
	assign res.is_resend = o_rs_q;
	assign res.last_of_run = o_last_q;
	assign res.status = o_st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (cmd_pop) begin
				act_q <= 1'b1;
			end else if (emit && emit_last) begin
				act_q <= 1'b0;
			end
			if (emit) begin
				ov_q <= 1'b1;
			end else if (res.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			so_q <= cmd.stat_only;
			cur_q <= cmd.start;
			rem_q <= cmd.cnt;
			rs_q <= cmd.resend;
			st_q <= cmd.status;
		end else if (emit) begin
			cur_q <= cur_q + SEQ_W'(1);
			rem_q <= rem_q - CNT_W'(1);
		end
		if (emit) begin
			o_segv_q <= !so_q;
			o_seg_q <= so_q ? '0 : cur_q;
			o_rs_q <= !so_q && rs_q;
			o_last_q <= emit_last;
			o_st_q <= st_q;
		end
	end

	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		act_q && !so_q |-> rem_q != '0)
		else $error("segment run active with no segments left");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		emit && !emit_last |=> act_q)
		else $error("run ended before its last result");

	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !o_segv_q |-> o_last_q)
		else $error("status-only result not marked last");

endmodule
